// ----- rtl/bsf_pkg.sv -----
// Package for the 3x3 box-sum shift filter.
// Field widths, register indexes and reset values; no dependencies.
package bsf_pkg;

	localparam int DATA_W = 8;
	localparam int CFG_W  = 11;
	localparam int POS_W  = 10;
	localparam int SUM_W  = 12;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;
	localparam logic [CFG_W-1:0] MIN_SIZE       = 11'd3;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]  pos_t;

endpackage

// ----- rtl/bsf_if.sv -----
// Valid/ready channels for the box-sum shift filter: cell stream in, result stream out.
// Depends on bsf_pkg.
interface bsf_in_if;
	import bsf_pkg::*;

	logic  valid;
	logic  ready;
	data_t cell_value;
	logic  frame_start;

	modport source (output valid, cell_value, frame_start, input ready);
	modport sink   (input valid, cell_value, frame_start, output ready);
endinterface

interface bsf_out_if;
	import bsf_pkg::*;

	logic  valid;
	logic  ready;
	data_t filtered_value;
	pos_t  out_row;
	pos_t  out_col;
	logic  frame_last;

	modport source (output valid, filtered_value, out_row, out_col, frame_last, input ready);
	modport sink   (input valid, filtered_value, out_row, out_col, frame_last, output ready);
endinterface

// ----- rtl/box_sum_3x3_shift_filter_top.sv -----
// 3x3 box-sum filter, sum >> 3 saturated at 255; border cells give no result.
// Pipeline: an accepted cell is held in the stage-1 registers, its result in the output register.
// Throughput: one cell per cycle unless the output stalls; line stores read/written once per cell.
// Reset: position counters and window cleared, frame size registers set to 1024.
// The line stores are not cleared; an entry can be read before it has been written.
// Depends on bsf_pkg and bsf_if.
module box_sum_3x3_shift_filter_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bsf_pkg::CFG_W-1:0]        cfg_data,
	bsf_in_if.sink                           pix_in,
	bsf_out_if.source                        pix_out
);
	import bsf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	// configuration
	logic [CFG_W-1:0] frame_width_q, frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_SIZE_RESET;
			frame_height_q <= CFG_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [WW-1:0] w_lim, wm1;
	logic [HW-1:0] h_lim, hm1;

	always_comb begin
		if (frame_width_q < MIN_SIZE)
			w_lim = WW'(3);
		else if (32'(frame_width_q) > 32'(MAX_WIDTH))
			w_lim = WW'(MAX_WIDTH);
		else
			w_lim = WW'(frame_width_q);
		if (frame_height_q < MIN_SIZE)
			h_lim = HW'(3);
		else if (32'(frame_height_q) > 32'(MAX_HEIGHT))
			h_lim = HW'(MAX_HEIGHT);
		else
			h_lim = HW'(frame_height_q);
		wm1 = w_lim - WW'(1);
		hm1 = h_lim - HW'(1);
	end

	// stage 0: position and line-store read
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] c0;
	logic [RW-1:0] r0;
	logic [WW-1:0] c0_x;
	logic [HW-1:0] r0_x;
	logic          produce0, last0, accept;

	always_comb begin
		c0 = pix_in.frame_start ? '0 : col_q;
		r0 = pix_in.frame_start ? '0 : row_q;
		c0_x = WW'(c0);
		r0_x = HW'(r0);
		produce0 = (r0_x >= HW'(2)) && (r0_x <= hm1) && (c0_x >= WW'(2)) && (c0_x <= wm1);
		last0 = (r0_x == hm1) && (c0_x == wm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c0_x >= wm1) begin
				col_q <= '0;
				row_q <= (r0_x >= hm1) ? '0 : r0 + RW'(1);
			end else begin
				col_q <= c0 + CW'(1);
				row_q <= r0;
			end
		end
	end

	// line stores
	data_t prev_mem  [MAX_WIDTH];
	data_t prev2_mem [MAX_WIDTH];
	data_t rd_prev_s1, rd_prev2_s1;

	// stage 1 registers
	logic          valid_s1, produce_s1, last_s1;
	logic [CW-1:0] addr_s1;
	logic [RW-1:0] row_s1;
	data_t         cell_s1;
	logic          fwd_hit_s1;
	data_t         fwd_mid_s1, fwd_cell_s1;

	data_t top1, mid1;
	logic  s1_adv, s1_write;
	logic  out_valid_q;

	// a write to the same entry in the edge of the read is missed by the read
	assign top1 = fwd_hit_s1 ? fwd_mid_s1  : rd_prev2_s1;
	assign mid1 = fwd_hit_s1 ? fwd_cell_s1 : rd_prev_s1;

	assign s1_adv   = !produce_s1 || !out_valid_q || pix_out.ready;
	assign s1_write = valid_s1 && s1_adv;
	assign pix_in.ready = !valid_s1 || s1_adv;
	assign accept = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_prev_s1  <= prev_mem[c0];
			rd_prev2_s1 <= prev2_mem[c0];
		end
		if (s1_write) begin
			prev_mem[addr_s1]  <= cell_s1;
			prev2_mem[addr_s1] <= mid1;
		end
	end

	logic [WW-1:0] col_s1_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			produce_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1   <= 1'b1;
			produce_s1 <= produce0;
		end else if (s1_adv) begin
			valid_s1   <= 1'b0;
			produce_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= c0;
			row_s1      <= r0;
			cell_s1     <= pix_in.cell_value;
			last_s1     <= last0;
			fwd_hit_s1  <= s1_write && (addr_s1 == c0);
			fwd_mid_s1  <= mid1;
			fwd_cell_s1 <= cell_s1;
		end
	end

	// window: older column at [0..2], newer at [3..5], top/mid/bottom
	data_t win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (s1_write) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top1;
			win_q[4] <= mid1;
			win_q[5] <= cell_s1;
		end
	end

	logic [SUM_W-1:0] sum1;
	logic [SUM_W-4:0] shr1;
	data_t            val1;

	always_comb begin
		sum1 = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
			+ SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5])
			+ SUM_W'(top1) + SUM_W'(mid1) + SUM_W'(cell_s1);
		shr1 = sum1[SUM_W-1:3];
		val1 = shr1[SUM_W-4] ? '1 : shr1[DATA_W-1:0];
		col_s1_x = WW'(addr_s1);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_write && produce_s1) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	data_t filtered_q;
	pos_t  out_row_q, out_col_q;
	logic  frame_last_q;

	always_ff @(posedge clk) begin
		if (s1_write && produce_s1) begin
			filtered_q   <= val1;
			out_row_q    <= POS_W'(32'(row_s1) - 32'd1);
			out_col_q    <= POS_W'(32'(col_s1_x) - 32'd1);
			frame_last_q <= last_s1;
		end
	end

	assign pix_out.valid          = out_valid_q;
	assign pix_out.filtered_value = filtered_q;
	assign pix_out.out_row        = out_row_q;
	assign pix_out.out_col        = out_col_q;
	assign pix_out.frame_last     = frame_last_q;

endmodule

// ----- tb/sv/box_sum_3x3_shift_filter_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for box_sum_3x3_shift_filter_top: a cycle-free predictor of the
// 3x3 box sum (>>3, saturated), random stalls on both channels, field-by-field result checks.
// Depends on bsf_pkg, bsf_if and the filter top level.
module box_sum_3x3_shift_filter_top_tb;
	import bsf_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int MAX_SIZE      = 1024;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 200;
	localparam int LIMIT_CYCLES  = 1_000_000;

	typedef struct {
		data_t value;
		pos_t  row;
		pos_t  col;
		logic  last;
	} filt_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	bsf_in_if  cell_ch ();
	bsf_out_if result_ch ();

	box_sum_3x3_shift_filter_top #(
		.MAX_WIDTH  (MAX_SIZE),
		.MAX_HEIGHT (MAX_SIZE)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (cell_ch),
		.pix_out   (result_ch)
	);

	// predictor state
	logic [CFG_W-1:0] width_reg  = CFG_SIZE_RESET;
	logic [CFG_W-1:0] height_reg = CFG_SIZE_RESET;
	data_t            line_above     [MAX_SIZE];
	data_t            line_two_above [MAX_SIZE];
	data_t            win_cols [6];
	int unsigned      cur_row = 0;
	int unsigned      cur_col = 0;

	filt_result_t     pending_filtered [$];
	int unsigned      mismatch_count = 0;

	logic             steady    = 1'b0;
	logic             sink_hold = 1'b0;
	int unsigned      src_phase_left = 0;
	logic             src_calm = 1'b0;

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v);
		if (v < MIN_SIZE)
			return int'(MIN_SIZE);
		if (v > MAX_SIZE)
			return MAX_SIZE;
		return int'(v);
	endfunction

	function automatic void box_filter_predict(input data_t cell_val, input logic start);
		int unsigned  w, h, idx, total;
		data_t        top, mid;
		filt_result_t res;
		w = clamp_size(width_reg);
		h = clamp_size(height_reg);
		if (start) begin
			cur_row = 0;
			cur_col = 0;
		end
		idx = cur_col % MAX_SIZE;
		top = line_two_above[idx];
		mid = line_above[idx];
		if (cur_row >= 2 && cur_row <= h - 1 && cur_col >= 2 && cur_col <= w - 1) begin
			total = cell_val + top + mid;
			foreach (win_cols[k])
				total += win_cols[k];
			total = total >> 3;
			res.value = (total > 255) ? 8'hFF : data_t'(total);
			res.row   = pos_t'(cur_row - 1);
			res.col   = pos_t'(cur_col - 1);
			res.last  = (cur_row == h - 1 && cur_col == w - 1);
			pending_filtered.push_back(res);
		end
		win_cols[0] = win_cols[3];
		win_cols[1] = win_cols[4];
		win_cols[2] = win_cols[5];
		win_cols[3] = top;
		win_cols[4] = mid;
		win_cols[5] = cell_val;
		line_two_above[idx] = mid;
		line_above[idx]     = cell_val;
		if (cur_col >= w - 1) begin
			cur_col = 0;
			cur_row = (cur_row >= h - 1) ? 0 : cur_row + 1;
		end else begin
			cur_col++;
		end
	endfunction

	function automatic void check_field(input string field, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			mismatch_count++;
		end
	endfunction

	// outputs are sampled here at the rising edge; results first, then the accepted cell
	always @(posedge clk) begin : scoreboard
		filt_result_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_filtered.size() == 0) begin
					$error("unexpected result: row %0d col %0d value %0d",
						result_ch.out_row, result_ch.out_col, result_ch.filtered_value);
					mismatch_count++;
				end else begin
					want = pending_filtered.pop_front();
					check_field("filtered_value", want.value, result_ch.filtered_value);
					check_field("out_row", want.row, result_ch.out_row);
					check_field("out_col", want.col, result_ch.out_col);
					check_field("frame_last", want.last, result_ch.frame_last);
				end
			end
			if (cell_ch.valid && cell_ch.ready)
				box_filter_predict(cell_ch.cell_value, cell_ch.frame_start);
		end
	end

	// result receiver: random stall bursts in busy phases, long hold on request
	initial begin : result_sink
		int unsigned stall, phase_left;
		logic        calm;
		phase_left = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(16, 96);
				calm = ($urandom_range(0, 2) == 0);
			end
			phase_left--;
			if (sink_hold) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				sink_hold = 1'b0;
			end else if (!steady && !calm && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 10);
				result_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// returns at the edge where the cell is taken; valid stays up until the next falling edge
	task automatic send_cell(input data_t cell_val, input logic start);
		int unsigned gap;
		if (src_phase_left == 0) begin
			src_phase_left = $urandom_range(16, 96);
			src_calm = ($urandom_range(0, 2) == 0);
		end
		src_phase_left--;
		if (!steady && !src_calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			cell_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cell_ch.valid       <= 1'b1;
		cell_ch.cell_value  <= cell_val;
		cell_ch.frame_start <= start;
		@(posedge clk);
		while (!cell_ch.ready)
			@(posedge clk);
	endtask

	function automatic data_t pick_value(input int unsigned style);
		case (style)
			1: return 8'hFF;
			2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			3: return data_t'($urandom_range(0, 15));
			default: return data_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_cells(input int unsigned count, input logic first_start);
		for (int unsigned k = 0; k < count; k++)
			send_cell(pick_value($urandom_range(0, 7)), (k == 0) ? first_start : 1'b0);
	endtask

	// stop offering, wait out every pending result plus the pipe for result-less cells
	task automatic drain_results();
		@(negedge clk);
		cell_ch.valid <= 1'b0;
		while (pending_filtered.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_FRAME_WIDTH)
			width_reg = value;
		else
			height_reg = value;
	endtask

	// minimum size sometimes written as an under-range code that clamps to 3
	function automatic logic [CFG_W-1:0] size_code(input int unsigned n);
		if (n == 3 && $urandom_range(0, 1))
			return CFG_W'($urandom_range(0, 2));
		return CFG_W'(n);
	endfunction

	// 3x3 of full-scale cells: sum saturates, single result is the frame's last
	task automatic test_min_frame_saturation();
		write_reg(CFG_FRAME_WIDTH, 11'd0);
		write_reg(CFG_FRAME_HEIGHT, 11'd2);
		for (int unsigned k = 0; k < 9; k++)
			send_cell(8'hFF, k == 0);
		drain_results();
	endtask

	// width shrunk while the column counter sits past the new row end, then an implied
	// frame, then a frame_start on the last column of a row
	task automatic test_shrink_and_restart();
		write_reg(CFG_FRAME_WIDTH, 11'd5);
		write_reg(CFG_FRAME_HEIGHT, 11'd3);
		for (int unsigned k = 0; k < 13; k++)
			send_cell(data_t'(k * 21), k == 0);
		drain_results();
		write_reg(CFG_FRAME_WIDTH, 11'd3);
		for (int unsigned k = 0; k < 3; k++)
			send_cell(8'h5A, 1'b0);
		for (int unsigned k = 0; k < 9; k++)
			send_cell((k % 2) ? 8'hFF : 8'h00, k == 0);
		drain_results();
	endtask

	// receiver holds off long enough for the block to back up into its input
	task automatic test_output_backpressure();
		write_reg(CFG_FRAME_WIDTH, 11'd8);
		write_reg(CFG_FRAME_HEIGHT, 11'd6);
		sink_hold = 1'b1;
		send_cells(48, 1'b1);
		drain_results();
	endtask

	// sender stops mid-frame until everything is out, then finishes the frame
	task automatic test_source_pause();
		write_reg(CFG_FRAME_WIDTH, 11'd6);
		write_reg(CFG_FRAME_HEIGHT, 11'd5);
		send_cells(17, 1'b1);
		drain_results();
		send_cells(13, 1'b0);
		drain_results();
	endtask

	// groups of frames at one size: mostly whole frames, some cut short or restarted,
	// stray frame_start cells, and now and then a size shrink in mid-frame
	task automatic test_random_frames(input int unsigned item_budget);
		int unsigned sent, w, h, nframes, stop_at, style;
		logic        start;
		sent = 0;
		while (sent < item_budget) begin
			drain_results();
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			h = $urandom_range(3, 8);
			write_reg(CFG_FRAME_WIDTH, size_code(w));
			write_reg(CFG_FRAME_HEIGHT, size_code(h));
			nframes = $urandom_range(1, 3);
			for (int unsigned f = 0; f < nframes; f++) begin
				style = $urandom_range(0, 7);
				stop_at = (style == 0) ? $urandom_range(1, w * h - 1) : w * h;
				for (int unsigned k = 0; k < stop_at; k++) begin
					if (k == 0)
						start = (f == 0) || $urandom_range(0, 1);
					else
						start = ($urandom_range(0, 99) == 0);
					send_cell(pick_value(style), start);
				end
				sent += stop_at;
			end
			if ($urandom_range(0, 4) == 0) begin
				stop_at = $urandom_range(1, w * h - 1);
				send_cells(stop_at, 1'b1);
				drain_results();
				w = $urandom_range(3, w);
				h = $urandom_range(3, h);
				write_reg(CFG_FRAME_WIDTH, size_code(w));
				write_reg(CFG_FRAME_HEIGHT, size_code(h));
				send_cells(w * h + $urandom_range(0, w), 1'b0);
				sent += stop_at + w * h;
			end
		end
		drain_results();
	endtask

	// all-ones width code clamps to the widest row; height code 0 clamps to 3.
	// The row wrap at the clamped width shows once the row is shrunk and row 2 is reached.
	task automatic test_max_width();
		write_reg(CFG_FRAME_WIDTH, '1);
		write_reg(CFG_FRAME_HEIGHT, '0);
		send_cells(MAX_SIZE + 6, 1'b1);
		drain_results();
		write_reg(CFG_FRAME_WIDTH, 11'd8);
		send_cells(18, 1'b0);
		drain_results();
	endtask

	// over-range height clamps to the tallest frame: rows keep counting past 3
	task automatic test_max_height();
		write_reg(CFG_FRAME_WIDTH, 11'd1);
		write_reg(CFG_FRAME_HEIGHT, 11'd1025);
		send_cells(30, 1'b1);
		drain_results();
	endtask

	initial begin : test_sequence
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_FRAME_WIDTH;
		cfg_data            = '0;
		cell_ch.valid       = 1'b0;
		cell_ch.cell_value  = '0;
		cell_ch.frame_start = 1'b0;
		result_ch.ready     = 1'b0;
		foreach (win_cols[k])
			win_cols[k] = '0;
		foreach (line_above[k]) begin
			line_above[k]     = '0;
			line_two_above[k] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_min_frame_saturation();
		test_shrink_and_restart();
		test_output_backpressure();
		test_source_pause();
		test_random_frames(400);
		test_max_width();
		test_max_height();
		steady = 1'b1;
		test_random_frames(120);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bsf_pkg.sv
rtl/bsf_if.sv
rtl/box_sum_3x3_shift_filter_top.sv
tb/sv/box_sum_3x3_shift_filter_top_tb.sv
